// ----- rtl/ipl_pkg.sv -----
// Package for the image plane layout checker.
// Holds the configuration register type, register indexes, plane modes and
// shared width helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipl_pkg;

	localparam int DIM_BITS_DEF  = 14;
	localparam int ADDR_BITS_DEF = 32;
	localparam int PITCH_BITS    = 16;
	localparam int QUEUE_DEPTH   = 4;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 6;

	// Row bytes are (width * pixel_depth + ROUND_ADD) >> BYTE_SHIFT.
	localparam int ROUND_ADD  = 7;
	localparam int BYTE_SHIFT = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH_ALIGN  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT_ALIGN = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BPP          = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_COUNT  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_CHROMA_H     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_CHROMA_V     = 3'd5;

	localparam logic [1:0] PLANES_NONE   = 2'd0;
	localparam logic [1:0] PLANES_PACKED = 2'd1;
	localparam logic [1:0] PLANES_TWO    = 2'd2;
	localparam logic [1:0] PLANES_THREE  = 2'd3;

	typedef struct packed {
		logic [3:0] width_align_mask;
		logic [3:0] height_align_mask;
		logic [5:0] pixel_depth;
		logic [1:0] plane_count;
		logic [1:0] chroma_hshift;
		logic [1:0] chroma_vshift;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		width_align_mask:  4'd0,
		height_align_mask: 4'd0,
		pixel_depth:       6'd8,
		plane_count:       2'd1,
		chroma_hshift:     2'd1,
		chroma_vshift:     2'd1
	};

	// Width of a product pitch * (lines - 1).
	function automatic int prod_width(input int dim_bits);
		return PITCH_BITS + dim_bits;
	endfunction

	// Width of the minimum row bytes of plane zero.
	function automatic int row0_width(input int dim_bits);
		return dim_bits + 4;
	endfunction

	// Width of one queue entry between the front and the back.
	function automatic int entry_width(input int dim_bits, input int addr_bits);
		return 1 + 2 + 3 * prod_width(dim_bits) + row0_width(dim_bits) + dim_bits
			+ 4 * addr_bits;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ipl_queue.sv -----
// Short FIFO that decouples the classifying front from the checking back.
// Generic width; uses nothing from the package.
`timescale 1ns / 1ps
`default_nettype none

module ipl_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  push_full,
	output logic                  pop_valid,
	output logic [WIDTH-1:0]      pop_data,
	input  wire logic             pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_full = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];
	assign do_push   = push_valid && !push_full;
	assign do_pop    = pop_ready && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ipl_front.sv -----
// Front of the layout checker: accepts descriptors, does the dimension and
// pitch checks and forms the plane size products. Depends on ipl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipl_front import ipl_pkg::*; #(
	parameter int DIM_BITS  = DIM_BITS_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [DIM_BITS-1:0]   width,
	input  wire logic [DIM_BITS-1:0]   height,
	input  wire logic [PITCH_BITS-1:0] pitch_first,
	input  wire logic [PITCH_BITS-1:0] pitch_second,
	input  wire logic [PITCH_BITS-1:0] pitch_third,
	input  wire logic [ADDR_BITS-1:0]  offset_first,
	input  wire logic [ADDR_BITS-1:0]  offset_second,
	input  wire logic [ADDR_BITS-1:0]  offset_third,
	input  wire logic [ADDR_BITS-1:0]  buffer_bytes,
	output logic                       push_valid,
	output logic [entry_width(DIM_BITS, ADDR_BITS)-1:0] push_data,
	input  wire logic                  push_full
);

	localparam int PROD_W = prod_width(DIM_BITS);
	localparam int ROW0_W = row0_width(DIM_BITS);
	localparam int CMP_W  = (ROW0_W > PITCH_BITS) ? ROW0_W : PITCH_BITS;
	localparam int MUL_W  = DIM_BITS + 6;

	typedef struct packed {
		logic                 early_fail;
		logic [1:0]           planes;
		logic [PROD_W-1:0]    prod0;
		logic [PROD_W-1:0]    prod1;
		logic [PROD_W-1:0]    prod2;
		logic [ROW0_W-1:0]    row0;
		logic [DIM_BITS-1:0]  row_uv;
		logic [ADDR_BITS-1:0] off0;
		logic [ADDR_BITS-1:0] off1;
		logic [ADDR_BITS-1:0] off2;
		logic [ADDR_BITS-1:0] size;
	} entry_t;

	logic                  valid_s1;
	logic [DIM_BITS-1:0]   width_s1;
	logic [DIM_BITS-1:0]   height_s1;
	logic [PITCH_BITS-1:0] pitch0_s1;
	logic [PITCH_BITS-1:0] pitch1_s1;
	logic [PITCH_BITS-1:0] pitch2_s1;
	logic [ADDR_BITS-1:0]  off0_s1;
	logic [ADDR_BITS-1:0]  off1_s1;
	logic [ADDR_BITS-1:0]  off2_s1;
	logic [ADDR_BITS-1:0]  size_s1;

	logic [MUL_W-1:0]    wbpp;
	logic [MUL_W:0]      wbpp_rnd;
	logic [ROW0_W-1:0]   row0;
	logic [DIM_BITS-1:0] row_uv;
	logic [DIM_BITS-1:0] hm1;
	logic [DIM_BITS-1:0] ch;
	logic [DIM_BITS-1:0] chm1;
	logic [1:0]          planes;
	logic                fail_dim;
	logic                fail_p0;
	logic                fail_p1;
	logic                fail_p2;
	logic                fail_ch;
	entry_t              entry;

	assign in_ready = !valid_s1 || !push_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			width_s1  <= width;
			height_s1 <= height;
			pitch0_s1 <= pitch_first;
			pitch1_s1 <= pitch_second;
			pitch2_s1 <= pitch_third;
			off0_s1   <= offset_first;
			off1_s1   <= offset_second;
			off2_s1   <= offset_third;
			size_s1   <= buffer_bytes;
		end
	end

	always_comb begin
		wbpp     = MUL_W'(width_s1) * MUL_W'(cfg.pixel_depth);
		wbpp_rnd = (MUL_W + 1)'(wbpp) + (MUL_W + 1)'(ROUND_ADD);
		row0     = ROW0_W'(wbpp_rnd >> BYTE_SHIFT);
		row_uv   = width_s1 >> cfg.chroma_hshift;
		hm1      = height_s1 - 1'b1;
		ch       = height_s1 >> cfg.chroma_vshift;
		chm1     = ch - 1'b1;
		planes   = (cfg.plane_count == PLANES_NONE) ? PLANES_PACKED : cfg.plane_count;

		fail_dim = (width_s1 == '0) || (height_s1 == '0)
			|| ((width_s1 & DIM_BITS'(cfg.width_align_mask)) != '0)
			|| ((height_s1 & DIM_BITS'(cfg.height_align_mask)) != '0);
		fail_p0  = CMP_W'(pitch0_s1) < CMP_W'(row0);
		fail_p1  = CMP_W'(pitch1_s1) < CMP_W'(row_uv);
		fail_p2  = CMP_W'(pitch2_s1) < CMP_W'(row_uv);
		fail_ch  = (ch == '0);

		entry.planes = planes;
		case (planes)
			PLANES_TWO:   entry.early_fail = fail_dim || fail_p0 || fail_p1 || fail_ch;
			PLANES_THREE: entry.early_fail = fail_dim || fail_p0 || fail_p1 || fail_ch
				|| fail_p2;
			default:      entry.early_fail = fail_dim || fail_p0;
		endcase
		entry.prod0  = PROD_W'(pitch0_s1) * PROD_W'(hm1);
		entry.prod1  = PROD_W'(pitch1_s1) * PROD_W'(chm1);
		entry.prod2  = PROD_W'(pitch2_s1) * PROD_W'(chm1);
		entry.row0   = row0;
		entry.row_uv = row_uv;
		entry.off0   = off0_s1;
		entry.off1   = off1_s1;
		entry.off2   = off2_s1;
		entry.size   = size_s1;
	end

	assign push_valid = valid_s1;
	assign push_data  = entry;

endmodule

`default_nettype wire

// ----- rtl/ipl_back.sv -----
// Back of the layout checker: plane extents, offset ordering and the final
// overlap and overrun checks, ending in the result register. Depends on ipl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipl_back import ipl_pkg::*; #(
	parameter int DIM_BITS  = DIM_BITS_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pop_valid,
	input  wire logic [entry_width(DIM_BITS, ADDR_BITS)-1:0] pop_data,
	output logic      pop_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic      layout_ok
);

	localparam int PROD_W = prod_width(DIM_BITS);
	localparam int ROW0_W = row0_width(DIM_BITS);
	localparam int NEED_W = PROD_W + 1;
	localparam int SUM_W  = ((ADDR_BITS > NEED_W) ? ADDR_BITS : NEED_W) + 1;

	typedef struct packed {
		logic                 early_fail;
		logic [1:0]           planes;
		logic [PROD_W-1:0]    prod0;
		logic [PROD_W-1:0]    prod1;
		logic [PROD_W-1:0]    prod2;
		logic [ROW0_W-1:0]    row0;
		logic [DIM_BITS-1:0]  row_uv;
		logic [ADDR_BITS-1:0] off0;
		logic [ADDR_BITS-1:0] off1;
		logic [ADDR_BITS-1:0] off2;
		logic [ADDR_BITS-1:0] size;
	} entry_t;

	entry_t entry;

	// Stage one: plane sizes.
	logic                 valid_s1;
	logic                 fail_s1;
	logic [1:0]           planes_s1;
	logic [NEED_W-1:0]    need_s1 [3];
	logic [ADDR_BITS-1:0] off_s1 [3];
	logic [ADDR_BITS-1:0] size_s1;

	// Stage two: plane ends and offset order.
	logic                 valid_s2;
	logic                 fail_s2;
	logic [1:0]           planes_s2;
	logic [SUM_W-1:0]     end_s2 [3];
	logic [ADDR_BITS-1:0] off_s2 [3];
	logic [ADDR_BITS-1:0] size_s2;
	logic                 lt10_s2;
	logic                 lt20_s2;
	logic                 lt21_s2;

	logic out_valid_q;
	logic layout_ok_q;

	logic       en_out;
	logic       en_s2;
	logic       en_s1;
	logic [1:0] ia;
	logic [1:0] ib;
	logic [1:0] ic;
	logic       c_lt_b;
	logic       c_lt_a;
	logic       ok;

	assign entry     = pop_data;
	assign en_out    = !out_valid_q || out_ready;
	assign en_s2     = !valid_s2 || en_out;
	assign en_s1     = !valid_s1 || en_s2;
	assign pop_ready = en_s1;
	assign out_valid = out_valid_q;
	assign layout_ok = layout_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= pop_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && pop_valid) begin
			fail_s1    <= entry.early_fail;
			planes_s1  <= entry.planes;
			need_s1[0] <= NEED_W'(entry.prod0) + NEED_W'(entry.row0);
			need_s1[1] <= NEED_W'(entry.prod1) + NEED_W'(entry.row_uv);
			need_s1[2] <= NEED_W'(entry.prod2) + NEED_W'(entry.row_uv);
			off_s1[0]  <= entry.off0;
			off_s1[1]  <= entry.off1;
			off_s1[2]  <= entry.off2;
			size_s1    <= entry.size;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			fail_s2   <= fail_s1;
			planes_s2 <= planes_s1;
			for (int i = 0; i < 3; i++) begin
				end_s2[i] <= SUM_W'(off_s1[i]) + SUM_W'(need_s1[i]);
				off_s2[i] <= off_s1[i];
			end
			size_s2 <= size_s1;
			lt10_s2 <= off_s1[1] < off_s1[0];
			lt20_s2 <= off_s1[2] < off_s1[0];
			lt21_s2 <= off_s1[2] < off_s1[1];
		end
	end

	// Sort the planes by offset; ties keep plane order.
	always_comb begin
		ia = lt10_s2 ? 2'd1 : 2'd0;
		ib = lt10_s2 ? 2'd0 : 2'd1;
		ic = 2'd2;
		c_lt_b = lt10_s2 ? lt20_s2 : lt21_s2;
		c_lt_a = lt10_s2 ? lt21_s2 : lt20_s2;
		if (planes_s2 == PLANES_THREE && c_lt_b) begin
			ic = ib;
			if (c_lt_a) begin
				ib = ia;
				ia = 2'd2;
			end else begin
				ib = 2'd2;
			end
		end

		case (planes_s2)
			PLANES_TWO: begin
				ok = (end_s2[ib] <= SUM_W'(size_s2))
					&& (end_s2[ia] <= SUM_W'(off_s2[ib]));
			end
			PLANES_THREE: begin
				ok = (end_s2[ic] <= SUM_W'(size_s2))
					&& (end_s2[ib] <= SUM_W'(off_s2[ic]))
					&& (end_s2[ia] <= SUM_W'(off_s2[ib]));
			end
			default: begin
				ok = end_s2[0] <= SUM_W'(size_s2);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s2) begin
			layout_ok_q <= !fail_s2 && ok;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/image_plane_layout_checker.sv -----
// Top level of the image plane layout checker: configuration registers and
// the front, queue and back. Depends on ipl_pkg, ipl_front, ipl_queue, ipl_back.
//
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     width .. buffer_bytes (descriptor)
// out      output     out_valid / out_ready   layout_ok
// cfg      input      cfg_we (no wait)        cfg_index, cfg_data
//
// One item is accepted per cycle while in_ready is high; its result passes through the
// input register, queue, plane-size stage, plane-end stage and result register.
// Reset clears all valid flags and loads the register reset values.
// A stalled output fills the back stages and then the queue before in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module image_plane_layout_checker import ipl_pkg::*; #(
	parameter int DIM_BITS  = DIM_BITS_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [DIM_BITS-1:0]      width,
	input  wire logic [DIM_BITS-1:0]      height,
	input  wire logic [PITCH_BITS-1:0]    pitch_first,
	input  wire logic [PITCH_BITS-1:0]    pitch_second,
	input  wire logic [PITCH_BITS-1:0]    pitch_third,
	input  wire logic [ADDR_BITS-1:0]     offset_first,
	input  wire logic [ADDR_BITS-1:0]     offset_second,
	input  wire logic [ADDR_BITS-1:0]     offset_third,
	input  wire logic [ADDR_BITS-1:0]     buffer_bytes,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic                          layout_ok
);

	localparam int ENTRY_W = entry_width(DIM_BITS, ADDR_BITS);

	cfg_t               cfg_q;
	logic               push_valid;
	logic [ENTRY_W-1:0] push_data;
	logic               push_full;
	logic               pop_valid;
	logic [ENTRY_W-1:0] pop_data;
	logic               pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH_ALIGN:  cfg_q.width_align_mask  <= cfg_data[3:0];
				REG_HEIGHT_ALIGN: cfg_q.height_align_mask <= cfg_data[3:0];
				REG_BPP:          cfg_q.pixel_depth       <= cfg_data[5:0];
				REG_PLANE_COUNT:  cfg_q.plane_count       <= cfg_data[1:0];
				REG_CHROMA_H:     cfg_q.chroma_hshift     <= cfg_data[1:0];
				REG_CHROMA_V:     cfg_q.chroma_vshift     <= cfg_data[1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	ipl_front #(
		.DIM_BITS  (DIM_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.width         (width),
		.height        (height),
		.pitch_first   (pitch_first),
		.pitch_second  (pitch_second),
		.pitch_third   (pitch_third),
		.offset_first  (offset_first),
		.offset_second (offset_second),
		.offset_third  (offset_third),
		.buffer_bytes  (buffer_bytes),
		.push_valid    (push_valid),
		.push_data     (push_data),
		.push_full     (push_full)
	);

	ipl_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_full  (push_full),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	ipl_back #(
		.DIM_BITS  (DIM_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.layout_ok (layout_ok)
	);

endmodule

`default_nettype wire

// ----- verif/layout_result_checker.sv -----
// Result checker for the image plane layout checker: watches the configuration
// port and both channels, predicts layout_ok for each accepted descriptor and
// compares it with the results in order. Depends on ipl_pkg.
`timescale 1ns / 1ps

module layout_result_checker import ipl_pkg::*; #(
	parameter int DIM_BITS  = DIM_BITS_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [DIM_BITS-1:0]      width,
	input  logic [DIM_BITS-1:0]      height,
	input  logic [PITCH_BITS-1:0]    pitch_first,
	input  logic [PITCH_BITS-1:0]    pitch_second,
	input  logic [PITCH_BITS-1:0]    pitch_third,
	input  logic [ADDR_BITS-1:0]     offset_first,
	input  logic [ADDR_BITS-1:0]     offset_second,
	input  logic [ADDR_BITS-1:0]     offset_third,
	input  logic [ADDR_BITS-1:0]     buffer_bytes,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic                     layout_ok,
	output int                       mismatch_count,
	output int                       pending_results
);

	cfg_t shadow_cfg = CFG_RESET;
	bit   expected_ok_q[$];
	int   fail_count = 0;
	int   queued_count = 0;

	assign mismatch_count  = fail_count;
	assign pending_results = queued_count;

	// All sums are kept in 64 bits so that nothing wraps.
	function automatic bit predict_layout_ok(input cfg_t rc, input logic [63:0] w, h,
			p0, p1, p2, o0, o1, o2, size);
		logic [63:0] pitch [3];
		logic [63:0] off [3];
		logic [63:0] need [3];
		logic [63:0] row0, row_uv, ch;
		logic [1:0]  planes;
		int          a, b, hi_idx;
		pitch[0] = p0;
		pitch[1] = p1;
		pitch[2] = p2;
		off[0] = o0;
		off[1] = o1;
		off[2] = o2;
		planes = (rc.plane_count == PLANES_NONE) ? PLANES_PACKED : rc.plane_count;
		if (w == 0 || h == 0)
			return 1'b0;
		if (((w & 64'(rc.width_align_mask)) | (h & 64'(rc.height_align_mask))) != 0)
			return 1'b0;
		row0 = (w * 64'(rc.pixel_depth) + 64'(ROUND_ADD)) >> BYTE_SHIFT;
		if (pitch[0] < row0)
			return 1'b0;
		// The last line only needs its minimum bytes, not a whole pitch.
		need[0] = pitch[0] * (h - 1) + row0;
		if (planes == PLANES_PACKED)
			return off[0] + need[0] <= size;
		row_uv = w >> rc.chroma_hshift;
		if (pitch[1] < row_uv)
			return 1'b0;
		ch = h >> rc.chroma_vshift;
		if (ch == 0)
			return 1'b0;
		need[1] = pitch[1] * (ch - 1) + row_uv;
		a = (off[1] < off[0]) ? 1 : 0;
		b = 1 - a;
		if (planes == PLANES_TWO) begin
			if (off[b] + need[b] > size)
				return 1'b0;
			return off[a] + need[a] <= off[b];
		end
		if (pitch[2] < row_uv)
			return 1'b0;
		need[2] = pitch[2] * (ch - 1) + row_uv;
		// Stable sort by offset: ties keep plane order.
		hi_idx = 2;
		if (off[2] < off[b]) begin
			hi_idx = b;
			if (off[2] < off[a]) begin
				b = a;
				a = 2;
			end else begin
				b = 2;
			end
		end
		if (off[hi_idx] + need[hi_idx] > size)
			return 1'b0;
		if (off[b] + need[b] > off[hi_idx])
			return 1'b0;
		return off[a] + need[a] <= off[b];
	endfunction

	task automatic report_mismatch(input string what);
		if (fail_count < 50)
			$display("%0t ns layout check failed: %s", $time, what);
		fail_count++;
	endtask

	always @(posedge clk) begin
		bit want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_ok_q.size() == 0) begin
					report_mismatch("result with no descriptor outstanding");
				end else begin
					want = expected_ok_q.pop_front();
					if (layout_ok !== want)
						report_mismatch($sformatf("layout_ok is %b, predicted %b",
							layout_ok, want));
				end
			end
			if (in_valid && in_ready)
				expected_ok_q.push_back(predict_layout_ok(shadow_cfg, width, height,
					pitch_first, pitch_second, pitch_third, offset_first, offset_second,
					offset_third, buffer_bytes));
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH_ALIGN:  shadow_cfg.width_align_mask  = cfg_data[3:0];
					REG_HEIGHT_ALIGN: shadow_cfg.height_align_mask = cfg_data[3:0];
					REG_BPP:          shadow_cfg.pixel_depth       = cfg_data[5:0];
					REG_PLANE_COUNT:  shadow_cfg.plane_count       = cfg_data[1:0];
					REG_CHROMA_H:     shadow_cfg.chroma_hshift     = cfg_data[1:0];
					REG_CHROMA_V:     shadow_cfg.chroma_vshift     = cfg_data[1:0];
					default: ;
				endcase
			end
			queued_count <= expected_ok_q.size();
		end
	end

endmodule

// ----- verif/testbench.sv -----
// Top of the image plane layout checker testbench: clock, reset, descriptor and
// configuration stimulus, output back-pressure and the verdict.
// Depends on ipl_pkg, image_plane_layout_checker and layout_result_checker.
`timescale 1ns / 1ps

module testbench;
	import ipl_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd6;
	localparam int STALL_LIMIT      = 2000;
	localparam int RANDOM_PER_PHASE = 96;
	localparam int DRAIN_CYCLES     = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [DIM_BITS_DEF-1:0]  width = '0;
	logic [DIM_BITS_DEF-1:0]  height = '0;
	logic [PITCH_BITS-1:0]    pitch_first = '0;
	logic [PITCH_BITS-1:0]    pitch_second = '0;
	logic [PITCH_BITS-1:0]    pitch_third = '0;
	logic [ADDR_BITS_DEF-1:0] offset_first = '0;
	logic [ADDR_BITS_DEF-1:0] offset_second = '0;
	logic [ADDR_BITS_DEF-1:0] offset_third = '0;
	logic [ADDR_BITS_DEF-1:0] buffer_bytes = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic layout_ok;

	int   mismatch_count;
	int   pending_results;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   items_sent = 0;
	int   quiet_cycles = 0;
	cfg_t cur_cfg = CFG_RESET;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	image_plane_layout_checker i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.width(width), .height(height),
		.pitch_first(pitch_first), .pitch_second(pitch_second), .pitch_third(pitch_third),
		.offset_first(offset_first), .offset_second(offset_second),
		.offset_third(offset_third), .buffer_bytes(buffer_bytes),
		.out_valid(out_valid), .out_ready(out_ready), .layout_ok(layout_ok)
	);

	layout_result_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.width(width), .height(height),
		.pitch_first(pitch_first), .pitch_second(pitch_second), .pitch_third(pitch_third),
		.offset_first(offset_first), .offset_second(offset_second),
		.offset_third(offset_third), .buffer_bytes(buffer_bytes),
		.out_valid(out_valid), .out_ready(out_ready), .layout_ok(layout_ok),
		.mismatch_count(mismatch_count), .pending_results(pending_results)
	);

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// Ends the run when neither channel has moved an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[image_plane_layout_checker] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_desc(input logic [63:0] w, h, p0, p1, p2, o0, o1, o2, bb);
		if (items_sent < 400) begin
			send_idle_pct = 18;
			recv_idle_pct = 67;
		end else if (items_sent < 800) begin
			send_idle_pct = 67;
			recv_idle_pct = 18;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid      <= 1'b1;
		width         <= w[DIM_BITS_DEF-1:0];
		height        <= h[DIM_BITS_DEF-1:0];
		pitch_first   <= p0[PITCH_BITS-1:0];
		pitch_second  <= p1[PITCH_BITS-1:0];
		pitch_third   <= p2[PITCH_BITS-1:0];
		offset_first  <= o0[ADDR_BITS_DEF-1:0];
		offset_second <= o1[ADDR_BITS_DEF-1:0];
		offset_third  <= o2[ADDR_BITS_DEF-1:0];
		buffer_bytes  <= bb[ADDR_BITS_DEF-1:0];
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Drops valid and waits until every outstanding result has been taken.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(input cfg_t setting);
		logic [CFG_IDX_BITS-1:0]  reg_order [7];
		logic [CFG_DATA_BITS-1:0] data;
		reg_order = '{REG_WIDTH_ALIGN, REG_HEIGHT_ALIGN, REG_BPP, REG_PLANE_COUNT,
			REG_CHROMA_H, REG_CHROMA_V, REG_UNUSED};
		wait_idle();
		cfg_we <= 1'b1;
		for (int k = 0; k < 7; k++) begin
			// Bits above a register's width are random and must be dropped.
			data = CFG_DATA_BITS'($urandom);
			case (reg_order[k])
				REG_WIDTH_ALIGN:  data[3:0] = setting.width_align_mask;
				REG_HEIGHT_ALIGN: data[3:0] = setting.height_align_mask;
				REG_BPP:          data      = setting.pixel_depth;
				REG_PLANE_COUNT:  data[1:0] = setting.plane_count;
				REG_CHROMA_H:     data[1:0] = setting.chroma_hshift;
				REG_CHROMA_V:     data[1:0] = setting.chroma_vshift;
				default: ;
			endcase
			cfg_index <= reg_order[k];
			cfg_data  <= data;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_cfg = setting;
	endtask

	// Mostly well-formed layouts in a random plane order, some of them broken
	// by one field, and some pure noise.
	task automatic send_random_desc();
		logic [63:0] w, h, row0, row_uv, ch, bb, cursor;
		logic [63:0] p [3];
		logic [63:0] o [3];
		logic [63:0] need [3];
		int pc, j, tmp, k;
		int ord [3];
		for (k = 0; k < 3; k++) begin
			p[k] = $urandom_range(65535, 0);
			o[k] = $urandom;
			ord[k] = k;
		end
		if ($urandom_range(99) < 15) begin
			send_desc($urandom, $urandom, p[0], p[1], p[2], o[0], o[1], o[2], $urandom);
			return;
		end
		pc = (cur_cfg.plane_count == PLANES_NONE) ? 1 : int'(cur_cfg.plane_count);
		w = ($urandom_range(3) == 0) ? 64'($urandom_range(8192, 1))
			: 64'($urandom_range(256, 1));
		h = ($urandom_range(3) == 0) ? 64'($urandom_range(8192, 1))
			: 64'($urandom_range(256, 1));
		w = w & ~64'(cur_cfg.width_align_mask);
		h = h & ~64'(cur_cfg.height_align_mask);
		if (w == 0)
			w = 16;
		if (h == 0 || (pc > 1 && (h >> cur_cfg.chroma_vshift) == 0))
			h = 16;
		row0 = (w * 64'(cur_cfg.pixel_depth) + 64'(ROUND_ADD)) >> BYTE_SHIFT;
		row_uv = w >> cur_cfg.chroma_hshift;
		ch = h >> cur_cfg.chroma_vshift;
		p[0] = row0 + (($urandom_range(1) == 0) ? 0 : $urandom_range(64, 1));
		if (p[0] > 65535)
			p[0] = 65535;
		need[0] = p[0] * (h - 1) + row0;
		for (k = 1; k < pc; k++) begin
			p[k] = row_uv + (($urandom_range(1) == 0) ? 0 : $urandom_range(64, 1));
			if (p[k] > 65535)
				p[k] = 65535;
			need[k] = p[k] * (ch - 1) + row_uv;
		end
		for (k = pc - 1; k > 0; k--) begin
			j = $urandom_range(k, 0);
			tmp = ord[k];
			ord[k] = ord[j];
			ord[j] = tmp;
		end
		cursor = ($urandom_range(7) == 0) ? 64'($urandom_range(32'h3FFF_FFFF, 0))
			: 64'($urandom_range(4096, 0));
		for (k = 0; k < pc; k++) begin
			if (k > 0 && $urandom_range(1) == 1)
				cursor = cursor + $urandom_range(64, 1);
			o[ord[k]] = cursor;
			cursor = cursor + need[ord[k]];
		end
		bb = cursor + (($urandom_range(1) == 0) ? 0 : $urandom_range(100, 1));
		if (bb > 64'hFFFF_FFFF)
			bb = 64'hFFFF_FFFF;
		if ($urandom_range(99) < 40) begin
			case ($urandom_range(7, 0))
				0: w = w + 1;
				1: h = h + 1;
				2: p[0] = p[0] - 1;
				3: p[1] = p[1] - 1;
				4: p[2] = p[2] - 1;
				5: bb = bb - 1;
				6: begin
					k = $urandom_range(2, 0);
					o[k] = ($urandom_range(1) == 0) ? o[k] + 1 : o[k] - 1;
				end
				default: begin
					if ($urandom_range(1) == 0)
						w = 0;
					else
						h = 0;
				end
			endcase
		end
		send_desc(w, h, p[0], p[1], p[2], o[0], o[1], o[2], bb);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Packed format at reset values: 8 bits per pixel.
		send_desc(0, 1, 1, 0, 0, 0, 0, 0, 100);
		send_desc(1, 0, 1, 0, 0, 0, 0, 0, 100);
		send_desc(1, 1, 1, 0, 0, 0, 0, 0, 1);
		send_desc(1, 1, 1, 0, 0, 0, 0, 0, 0);
		send_desc(16383, 16383, 65535, 65535, 65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_desc(8192, 8192, 8192, 0, 0, 0, 0, 0, 8192 * 8192);
		send_desc(100, 4, 99, 0, 0, 0, 0, 0, 1000);
		// The end of the plane lies past 32 bits and must not wrap.
		send_desc(1, 1, 1, 0, 0, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF);
		// The last line is not padded to a full pitch.
		send_desc(10, 3, 16, 0, 0, 0, 0, 0, 42);
		repeat (RANDOM_PER_PHASE) send_random_desc();

		// Two planes: the third offset and pitch are ignored.
		apply_config('{4'd0, 4'd0, 6'd8, PLANES_TWO, 2'd1, 2'd1});
		send_desc(64, 32, 64, 32, 0, 0, 2048, 0, 2560);
		send_desc(64, 32, 64, 32, 0, 512, 0, 0, 2560);
		send_desc(64, 32, 64, 32, 0, 0, 2048, 0, 2559);
		send_desc(64, 32, 64, 32, 0, 0, 2047, 0, 2560);
		send_desc(64, 32, 64, 32, 0, 0, 0, 0, 2560);
		send_desc(64, 1, 64, 32, 0, 0, 64, 0, 4096);
		send_desc(64, 32, 64, 31, 0, 0, 2048, 0, 2560);
		repeat (RANDOM_PER_PHASE) send_random_desc();

		apply_config('{4'd0, 4'd0, 6'd8, PLANES_THREE, 2'd1, 2'd1});
		send_desc(64, 32, 64, 32, 32, 1024, 512, 0, 3072);
		send_desc(64, 32, 64, 32, 32, 1024, 0, 512, 3072);
		send_desc(64, 32, 64, 32, 32, 0, 2559, 2048, 3072);
		send_desc(64, 32, 64, 32, 32, 0, 2048, 2560, 3072);
		send_desc(64, 32, 64, 32, 31, 0, 2048, 2560, 3072);
		repeat (RANDOM_PER_PHASE) send_random_desc();

		apply_config('{4'd15, 4'd15, 6'd32, PLANES_THREE, 2'd0, 2'd0});
		repeat (RANDOM_PER_PHASE) send_random_desc();

		apply_config('{4'd1, 4'd3, 6'd1, PLANES_TWO, 2'd2, 2'd2});
		repeat (RANDOM_PER_PHASE) send_random_desc();

		// Zero bits per pixel gives an empty first plane, so a tie in offset passes.
		apply_config('{4'd0, 4'd0, 6'd0, PLANES_TWO, 2'd3, 2'd3});
		send_desc(16, 16, 0, 2, 0, 100, 100, 0, 104);
		repeat (RANDOM_PER_PHASE) send_random_desc();

		// A plane count of zero behaves as packed.
		apply_config('{4'd7, 4'd0, 6'd63, PLANES_NONE, 2'd3, 2'd3});
		send_desc(8, 1, 63, 0, 0, 0, 0, 0, 63);
		send_desc(8, 1, 63, 0, 0, 0, 0, 0, 62);
		repeat (RANDOM_PER_PHASE) send_random_desc();

		apply_config('{4'd0, 4'd15, 6'd16, PLANES_THREE, 2'd2, 2'd0});
		repeat (RANDOM_PER_PHASE) send_random_desc();

		apply_config('{4'd3, 4'd1, 6'd24, PLANES_TWO, 2'd0, 2'd2});
		repeat (RANDOM_PER_PHASE) send_random_desc();

		apply_config('{4'd8, 4'd4, 6'd12, PLANES_THREE, 2'd3, 2'd1});
		repeat (RANDOM_PER_PHASE) send_random_desc();

		apply_config('{4'd0, 4'd0, 6'd32, PLANES_PACKED, 2'd0, 2'd0});
		repeat (RANDOM_PER_PHASE) send_random_desc();

		apply_config('{4'd15, 4'd0, 6'd1, PLANES_THREE, 2'd2, 2'd3});
		repeat (RANDOM_PER_PHASE) send_random_desc();

		wait_idle();
		if (mismatch_count == 0)
			$display("[image_plane_layout_checker] OK");
		else
			$display("[image_plane_layout_checker] ERROR");
		$finish;
	end

endmodule
